### rtl/core/tcna_pkg.sv
// Package with widths, payload types and helpers for the triangle geometry pipeline.
`timescale 1ns / 1ps
package tcna_pkg;
  localparam int COORD_WIDTH      = 24;
  localparam int NORMAL_FRAC_BITS = 30;
  localparam int EDGE_WIDTH       = COORD_WIDTH + 1;
  localparam int CROSS_WIDTH      = 2 * EDGE_WIDTH + 1;
  localparam int MAG_CROSS_WIDTH  = CROSS_WIDTH - 1;
  localparam int SUMSQ_WIDTH      = 2 * MAG_CROSS_WIDTH + 2;
  localparam int ROOT_WIDTH       = SUMSQ_WIDTH / 2;
  localparam int AREA_WIDTH       = 50;
  localparam int NORMAL_WIDTH     = 32;
  localparam int QUOT_WIDTH       = NORMAL_FRAC_BITS + 2;
  localparam int NUM_WIDTH        = MAG_CROSS_WIDTH + NORMAL_FRAC_BITS + 1;
  localparam int DEN_WIDTH        = ROOT_WIDTH + 1;
  localparam int CSUM_WIDTH       = COORD_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0]  coord_t;
  typedef logic [MAG_CROSS_WIDTH-1:0]     cmag_t;
  typedef logic [ROOT_WIDTH-1:0]          root_t;
  typedef logic [SUMSQ_WIDTH-1:0]         sumsq_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } cent_t;

  typedef struct packed {
    cmag_t [2:0] mag;
    logic  [2:0] neg;
  } cross_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    logic signed [NORMAL_WIDTH-1:0] nx;
    logic signed [NORMAL_WIDTH-1:0] ny;
    logic signed [NORMAL_WIDTH-1:0] nz;
    logic [AREA_WIDTH-1:0] area;
    logic degen;
  } result_t;

  // Rounded mean of three coordinates, ties cannot occur.
  function automatic coord_t mean3(input coord_t a, input coord_t b, input coord_t c);
    logic signed [CSUM_WIDTH-1:0] s;
    logic [CSUM_WIDTH-1:0] m;
    logic [CSUM_WIDTH+26:0] q;
    logic [CSUM_WIDTH-1:0] qq;
    s = CSUM_WIDTH'(a) + CSUM_WIDTH'(b) + CSUM_WIDTH'(c);
    m = s[CSUM_WIDTH-1] ? CSUM_WIDTH'(-s) : CSUM_WIDTH'(s);
    // (m+1)/3 through the reciprocal (2^27+1)/3, exact for every sum below 2^27.
    q = (CSUM_WIDTH+27)'(m + 1'b1) * (CSUM_WIDTH+27)'(27'd44739243);
    qq = q[CSUM_WIDTH+26:27];
    mean3 = s[CSUM_WIDTH-1] ? COORD_WIDTH'(-qq) : COORD_WIDTH'(qq);
  endfunction
endpackage

### rtl/core/tcna_cross.sv
// Edge vectors, exact cross product and squared length, six register stages.
`timescale 1ns / 1ps
module tcna_cross (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  tcna_pkg::coord_t p [9],
  output logic vout,
  output tcna_pkg::cross_t cr,
  output tcna_pkg::sumsq_t sumsq,
  output tcna_pkg::cent_t cent
);
  import tcna_pkg::*;
  localparam int HW = MAG_CROSS_WIDTH / 2;
  typedef logic signed [EDGE_WIDTH-1:0] edge_t;
  typedef logic signed [2*EDGE_WIDTH-1:0] prod_t;
  typedef logic [2*HW-1:0] part_t;
  edge_t e1 [3], e2 [3];
  prod_t pa [3], pb [3];
  cent_t c1, c2, c3, c4, c5;
  cross_t x3, x4, x5;
  part_t hh [3], hl [3], ll [3];
  logic [2*MAG_CROSS_WIDTH-1:0] sq [3];
  logic [4:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      vout <= 1'b0;
    end else if (en) begin
      v <= {v[3:0], vin};
      vout <= v[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= EDGE_WIDTH'(p[3+k]) - EDGE_WIDTH'(p[k]);
        e2[k] <= EDGE_WIDTH'(p[6+k]) - EDGE_WIDTH'(p[k]);
      end
      c1 <= '{mean3(p[0], p[3], p[6]), mean3(p[1], p[4], p[7]), mean3(p[2], p[5], p[8])};
      pa[0] <= e1[1] * e2[2];  pb[0] <= e1[2] * e2[1];
      pa[1] <= e1[2] * e2[0];  pb[1] <= e1[0] * e2[2];
      pa[2] <= e1[0] * e2[1];  pb[2] <= e1[1] * e2[0];
      c2 <= c1;
      for (int k = 0; k < 3; k++) begin
        logic signed [CROSS_WIDTH-1:0] d;
        d = CROSS_WIDTH'(pa[k]) - CROSS_WIDTH'(pb[k]);
        x3.neg[k] <= d[CROSS_WIDTH-1];
        x3.mag[k] <= d[CROSS_WIDTH-1] ? MAG_CROSS_WIDTH'(-d) : MAG_CROSS_WIDTH'(d);
      end
      c3 <= c2;
      // Each square is split into half-width partial products.
      for (int k = 0; k < 3; k++) begin
        hh[k] <= part_t'(x3.mag[k][2*HW-1:HW]) * x3.mag[k][2*HW-1:HW];
        hl[k] <= part_t'(x3.mag[k][2*HW-1:HW]) * x3.mag[k][HW-1:0];
        ll[k] <= part_t'(x3.mag[k][HW-1:0]) * x3.mag[k][HW-1:0];
      end
      x4 <= x3;
      c4 <= c3;
      for (int k = 0; k < 3; k++)
        sq[k] <= (2*MAG_CROSS_WIDTH)'({hh[k], ll[k]})
               + ((2*MAG_CROSS_WIDTH)'(hl[k]) << (HW + 1));
      x5 <= x4;
      c5 <= c4;
      cr <= x5;
      cent <= c5;
      sumsq <= SUMSQ_WIDTH'(sq[0]) + SUMSQ_WIDTH'(sq[1]) + SUMSQ_WIDTH'(sq[2]);
    end
  end
endmodule

### rtl/core/tcna_sqrt.sv
// Pipelined floor integer square root, one result bit per stage, payload riding along.
`timescale 1ns / 1ps
module tcna_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  tcna_pkg::sumsq_t n,
  input  tcna_pkg::cross_t cr_in,
  input  tcna_pkg::cent_t cent_in,
  output logic vout,
  output tcna_pkg::root_t root,
  output tcna_pkg::cross_t cr_out,
  output tcna_pkg::cent_t cent_out
);
  import tcna_pkg::*;
  localparam int S = ROOT_WIDTH;
  // Restoring square root: remainder and root per stage.
  logic [S+1:0] rem [S+1];
  logic [S-1:0] rt [S+1];
  sumsq_t nn [S+1];
  cross_t cr [S+1];
  cent_t ce [S+1];
  logic [S:0] v;

  always_comb begin
    rem[0] = '0; rt[0] = '0; nn[0] = n; cr[0] = cr_in; ce[0] = cent_in; v[0] = vin;
  end

  for (genvar i = 0; i < S; i++) begin : g_st
    logic [S+1:0] t, tr;
    always_comb begin
      t  = {rem[i][S-1:0], nn[i][SUMSQ_WIDTH-1 -: 2]};
      tr = {rt[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (en) v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= tr) begin
          rem[i+1] <= t - tr;
          rt[i+1] <= {rt[i][S-2:0], 1'b1};
        end else begin
          rem[i+1] <= t;
          rt[i+1] <= {rt[i][S-2:0], 1'b0};
        end
        nn[i+1] <= {nn[i][SUMSQ_WIDTH-3:0], 2'b00};
        cr[i+1] <= cr[i];
        ce[i+1] <= ce[i];
      end
    end
  end

  assign vout = v[S];
  assign root = rt[S];
  assign cr_out = cr[S];
  assign cent_out = ce[S];
endmodule

### rtl/core/tcna_norm.sv
// Degenerate test and three pipelined restoring dividers for the unit normal.
`timescale 1ns / 1ps
module tcna_norm (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  tcna_pkg::root_t root,
  input  tcna_pkg::cross_t cr_in,
  input  tcna_pkg::cent_t cent_in,
  input  logic [tcna_pkg::AREA_WIDTH-1:0] thr,
  output logic vout,
  output tcna_pkg::result_t res
);
  import tcna_pkg::*;
  localparam int Q = QUOT_WIDTH;
  localparam int RW = DEN_WIDTH + 1;
  typedef struct packed {
    logic degen;
    logic [AREA_WIDTH-1:0] area;
    cent_t ce;
    logic [2:0] neg;
    logic [DEN_WIDTH-1:0] den;
  } side_t;

  side_t sd [Q+2];
  logic [NUM_WIDTH-1:0] num [Q+2][3];
  logic [RW-1:0] rem [Q+2][3];
  logic [Q-1:0] quo [Q+2][3];
  logic [Q+1:0] v;

  // Stage 0: threshold test, numerator 2*c*2^F + m, denominator 2*m.
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else if (en) v[0] <= vin;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      logic big;
      big = (ROOT_WIDTH > AREA_WIDTH) && ((root >> AREA_WIDTH) != '0);
      sd[0].degen <= !big && (AREA_WIDTH'(root) <= thr);
      sd[0].area <= big ? '1 : AREA_WIDTH'(root);
      sd[0].ce <= cent_in;
      sd[0].neg <= cr_in.neg;
      sd[0].den <= {root, 1'b0};
      for (int k = 0; k < 3; k++) begin
        num[0][k] <= (NUM_WIDTH'(cr_in.mag[k]) << (NORMAL_FRAC_BITS + 1)) + NUM_WIDTH'(root);
        rem[0][k] <= '0;
        quo[0][k] <= '0;
      end
    end
  end

  // The quotient fits in Q bits; the top numerator bits are preloaded as remainder.
  localparam int PRE = NUM_WIDTH - Q;
  for (genvar i = 0; i <= Q; i++) begin : g_dv
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (en) v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        for (int k = 0; k < 3; k++) begin
          logic [RW-1:0] t;
          if (i == 0) begin
            rem[i+1][k] <= RW'(num[i][k] >> Q);
            quo[i+1][k] <= '0;
            num[i+1][k] <= num[i][k];
          end else begin
            t = {rem[i][k][RW-2:0], num[i][k][Q-i]};
            if (t >= RW'(sd[i].den)) begin
              rem[i+1][k] <= t - RW'(sd[i].den);
              quo[i+1][k] <= {quo[i][k][Q-2:0], 1'b1};
            end else begin
              rem[i+1][k] <= t;
              quo[i+1][k] <= {quo[i][k][Q-2:0], 1'b0};
            end
            num[i+1][k] <= num[i][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= v[Q+1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [NORMAL_WIDTH-1:0] nv [3];
      for (int k = 0; k < 3; k++) begin
        nv[k] = NORMAL_WIDTH'(quo[Q+1][k]);
        if (sd[Q+1].neg[k]) nv[k] = -nv[k];
        if (sd[Q+1].degen) nv[k] = '0;
      end
      res.cx <= sd[Q+1].ce.cx;
      res.cy <= sd[Q+1].ce.cy;
      res.cz <= sd[Q+1].ce.cz;
      res.nx <= nv[0];
      res.ny <= nv[1];
      res.nz <= nv[2];
      res.area <= sd[Q+1].area;
      res.degen <= sd[Q+1].degen;
    end
  end
  logic unused;
  assign unused = ^{PRE, rem[0][0]};
endmodule

### rtl/core/triangle_centroid_normal_area_top.sv
// Top level of the triangle centroid, unit normal and area pipeline.
`timescale 1ns / 1ps
//  channel   direction  handshake             word
//  in        input      in_valid / in_ready   nine Q12.12 vertex coordinates
//  out       output     out_valid / out_ready centroid, normal, area, degenerate flag
//  cfg       input      cfg_we / cfg_data     degenerate threshold, Q26.24
//
// One word enters per cycle unless the output stalls; a result passes through the
// six cross product stages, the bit-serial square root stages and the
// one-bit-per-stage normal dividers.
// The whole pipeline advances together; when the output word is waiting and not
// taken, every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits and the threshold register.
module triangle_centroid_normal_area_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tcna_pkg::coord_t p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
  output logic out_valid,
  input  logic out_ready,
  output tcna_pkg::coord_t centroid_x, centroid_y, centroid_z,
  output logic signed [31:0] normal_x, normal_y, normal_z,
  output logic [49:0] tri_area,
  output logic degenerate,
  input  logic cfg_we,
  input  logic [49:0] cfg_data
);
  import tcna_pkg::*;
  logic [AREA_WIDTH-1:0] thr;
  logic en, v1, v2;
  coord_t p [9];
  cross_t cr1, cr2;
  sumsq_t ss;
  cent_t ce1, ce2;
  root_t root;
  result_t res;

  // The pipeline moves whenever the last stage is empty or being drained.
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) thr <= '0;
    else if (cfg_we) thr <= cfg_data;
  end

  assign p = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};

  tcna_cross u_cross (.clk, .rst, .en, .vin(in_valid), .p, .vout(v1), .cr(cr1),
                      .sumsq(ss), .cent(ce1));
  tcna_sqrt u_sqrt (.clk, .rst, .en, .vin(v1), .n(ss), .cr_in(cr1), .cent_in(ce1),
                    .vout(v2), .root, .cr_out(cr2), .cent_out(ce2));
  tcna_norm u_norm (.clk, .rst, .en, .vin(v2), .root, .cr_in(cr2), .cent_in(ce2),
                    .thr, .vout(out_valid), .res);

  assign centroid_x = res.cx;
  assign centroid_y = res.cy;
  assign centroid_z = res.cz;
  assign normal_x = res.nx;
  assign normal_y = res.ny;
  assign normal_z = res.nz;
  assign tri_area = res.area;
  assign degenerate = res.degen;
endmodule
